@@ design/mlfq_pkg.sv @@
// Shared types and constants for the four-level feedback scheduler.
// No dependencies; used by mlfq_four_level_scheduler.
`default_nettype none
package mlfq_pkg;

   localparam int LEVELS         = 4;
   localparam int LVL_BITS       = 2;
   localparam int QUANTUM_BITS   = 8;
   localparam int USED_BITS      = 8;
   localparam int CSR_INDEX_BITS = 8;

   typedef logic [LVL_BITS-1:0]     lvl_type;
   typedef logic [QUANTUM_BITS-1:0] quantum_type;
   typedef logic [USED_BITS-1:0]    used_type;

   localparam lvl_type TOP_LEVEL = lvl_type'(3);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam used_type USED_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUANTUM0 = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUANTUM1 = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUANTUM2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUANTUM3 = CSR_INDEX_BITS'(3);

   localparam quantum_type QUANTUM0_RESET = quantum_type'(2);
   localparam quantum_type QUANTUM1_RESET = quantum_type'(4);
   localparam quantum_type QUANTUM2_RESET = quantum_type'(8);
   localparam quantum_type QUANTUM3_RESET = quantum_type'(16);

endpackage
`default_nettype wire

@@ design/mlfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-level process id queues.
`default_nettype none
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/mlfq_four_level_scheduler.sv @@
// Four-level feedback scheduler: per-level id queues, running slot, quantum registers.
// Depends on mlfq_pkg and mlfq_ram.
//
//  channel   handshake             payload
//  request   start / busy          req_op, req_proc_id, req_proc_priority, req_executed
//  result    rsp_valid (strobe)    rsp_busy_res, rsp_running_id, rsp_running_level,
//                                  rsp_switched, rsp_dropped
//  csr       csr_valid / csr_ready csr_index, csr_data
//
// A request is accepted, then executed: the accept edge issues the RAM read, and the
// following cycle (busy high) uses the read data and writes any added or evicted id.
// The result strobe follows in the next cycle, while a new request may be accepted.
// Reset is synchronous and needs no clearing pass: fill counts cover the queue RAM.
// The result side cannot stall; csr_ready is always high.
`default_nettype none
module mlfq_four_level_scheduler #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_op,
   input  wire logic [ID_BITS-1:0]                   req_proc_id,
   input  wire logic signed [3:0]                    req_proc_priority,
   input  wire logic                                 req_executed,
   output logic                                      rsp_valid,
   output logic                                      rsp_busy_res,
   output logic [ID_BITS-1:0]                        rsp_running_id,
   output logic [mlfq_pkg::LVL_BITS-1:0]             rsp_running_level,
   output logic                                      rsp_switched,
   output logic                                      rsp_dropped,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mlfq_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mlfq_pkg::QUANTUM_BITS-1:0]    csr_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int ADDR_W = mlfq_pkg::LVL_BITS + PTR_W;
   localparam int RAM_DEPTH = mlfq_pkg::LEVELS << PTR_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   logic                  r_op_ff;
   logic [ID_BITS-1:0]    r_id_ff;
   mlfq_pkg::lvl_type     r_lvl_ff;
   logic                  r_exec_ff;
   mlfq_pkg::lvl_type     req_lvl;

   logic [PTR_W-1:0]      head_ff  [mlfq_pkg::LEVELS];
   logic [PTR_W-1:0]      head_in  [mlfq_pkg::LEVELS];
   logic [CNT_W-1:0]      count_ff [mlfq_pkg::LEVELS];
   logic [CNT_W-1:0]      count_in [mlfq_pkg::LEVELS];

   logic                  slot_busy_ff, slot_busy_in;
   logic [ID_BITS-1:0]    slot_id_ff, slot_id_in;
   mlfq_pkg::lvl_type     slot_level_ff, slot_level_in;
   mlfq_pkg::used_type    used_ff, used_in, used_inc;

   mlfq_pkg::quantum_type quantum_ff [mlfq_pkg::LEVELS];

   logic                  rsp_valid_ff;
   logic                  rsp_busy_ff;
   logic [ID_BITS-1:0]    rsp_id_ff;
   mlfq_pkg::lvl_type     rsp_level_ff;
   logic                  rsp_switched_ff;
   logic                  rsp_dropped_ff;

   logic                  accept;
   logic                  any_waiting;
   mlfq_pkg::lvl_type     best_lvl;
   logic [ID_BITS-1:0]    rd_data;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ID_BITS-1:0]    wr_data;
   logic                  pop, push, sw, drop;
   mlfq_pkg::lvl_type     push_lvl, new_lvl;
   logic [ID_BITS-1:0]    push_id;
   logic [PTR_W:0]        head_next;
   logic [SUM_W-1:0]      pos_sum;
   logic                  count_over;

   assign busy      = (state_ff == S_EXEC);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_proc_priority[3]) begin
         req_lvl = '0;
      end else if (req_proc_priority[2]) begin
         req_lvl = mlfq_pkg::TOP_LEVEL;
      end else begin
         req_lvl = mlfq_pkg::lvl_type'(req_proc_priority[1:0]);
      end
   end

   always_comb begin
      any_waiting = 1'b0;
      best_lvl    = '0;
      for (int i = mlfq_pkg::LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            any_waiting = 1'b1;
            best_lvl    = mlfq_pkg::lvl_type'(i);
         end
      end
   end

   mlfq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr ({best_lvl, head_ff[best_lvl]}),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      slot_busy_in  = slot_busy_ff;
      slot_id_in    = slot_id_ff;
      slot_level_in = slot_level_ff;
      used_in       = used_ff;
      pop           = 1'b0;
      push          = 1'b0;
      push_lvl      = r_lvl_ff;
      push_id       = r_id_ff;
      sw            = 1'b0;
      drop          = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = push_id;
      used_inc      = (r_exec_ff && used_ff != mlfq_pkg::USED_MAX) ? used_ff + 1'b1 : used_ff;
      new_lvl       = (slot_level_ff == mlfq_pkg::TOP_LEVEL) ? mlfq_pkg::TOP_LEVEL
                                                           : slot_level_ff + 1'b1;
      head_next     = '0;
      pos_sum       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (r_op_ff == mlfq_pkg::OP_ADD) begin
               push = 1'b1;
            end else if (!slot_busy_ff) begin
               if (any_waiting) begin
                  pop           = 1'b1;
                  slot_busy_in  = 1'b1;
                  slot_id_in    = rd_data;
                  slot_level_in = best_lvl;
                  used_in       = '0;
                  sw            = 1'b1;
               end
            end else if (used_inc >= quantum_ff[slot_level_ff]) begin
               used_in = '0;
               if (any_waiting) begin
                  pop           = 1'b1;
                  slot_id_in    = rd_data;
                  slot_level_in = best_lvl;
                  sw            = 1'b1;
                  push          = 1'b1;
                  push_lvl      = new_lvl;
                  push_id       = slot_id_ff;
               end else begin
                  slot_level_in = new_lvl;
               end
            end else begin
               used_in = used_inc;
            end

            if (pop) begin
               head_next = {1'b0, head_ff[best_lvl]} + 1'b1;
               head_in[best_lvl]  = (head_next == (PTR_W+1)'(QUEUE_DEPTH))
                                    ? '0 : head_next[PTR_W-1:0];
               count_in[best_lvl] = count_ff[best_lvl] - 1'b1;
            end

            if (push) begin
               if (count_in[push_lvl] >= CNT_W'(QUEUE_DEPTH)) begin
                  drop = 1'b1;
               end else begin
                  pos_sum = SUM_W'(head_ff[push_lvl]) + SUM_W'(count_ff[push_lvl]);
                  if (pos_sum >= SUM_W'(QUEUE_DEPTH)) begin
                     pos_sum = pos_sum - SUM_W'(QUEUE_DEPTH);
                  end
                  wr_en              = 1'b1;
                  wr_addr            = {push_lvl, pos_sum[PTR_W-1:0]};
                  wr_data            = push_id;
                  count_in[push_lvl] = count_in[push_lvl] + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_busy_ff  <= 1'b0;
         slot_id_ff    <= '0;
         slot_level_ff <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         slot_busy_ff  <= slot_busy_in;
         slot_id_ff    <= slot_id_in;
         slot_level_ff <= slot_level_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= busy;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff[0] <= mlfq_pkg::QUANTUM0_RESET;
         quantum_ff[1] <= mlfq_pkg::QUANTUM1_RESET;
         quantum_ff[2] <= mlfq_pkg::QUANTUM2_RESET;
         quantum_ff[3] <= mlfq_pkg::QUANTUM3_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mlfq_pkg::CSR_QUANTUM0: quantum_ff[0] <= csr_data;
            mlfq_pkg::CSR_QUANTUM1: quantum_ff[1] <= csr_data;
            mlfq_pkg::CSR_QUANTUM2: quantum_ff[2] <= csr_data;
            mlfq_pkg::CSR_QUANTUM3: quantum_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // hold the accepted request for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         r_op_ff   <= req_op;
         r_id_ff   <= req_proc_id;
         r_lvl_ff  <= req_lvl;
         r_exec_ff <= req_executed;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_busy_ff     <= slot_busy_in;
         rsp_id_ff       <= slot_busy_in ? slot_id_in : '0;
         rsp_level_ff    <= slot_busy_in ? slot_level_in : '0;
         rsp_switched_ff <= sw;
         rsp_dropped_ff  <= drop;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_running_id    = rsp_id_ff;
   assign rsp_running_level = rsp_level_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_dropped       = rsp_dropped_ff;

   always_comb begin
      count_over = 1'b0;
      for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
         if (count_ff[i] > CNT_W'(QUEUE_DEPTH)) begin
            count_over = 1'b1;
         end
      end
   end

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("execute cycle lasted more than one cycle");

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding execute cycle");

   a_switch_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> rsp_busy_res)
      else $error("switch reported with an idle slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !count_over)
      else $error("queue fill count beyond depth");

   a_slot_stays: assert property (@(posedge clock) disable iff (reset)
      slot_busy_ff |=> slot_busy_ff)
      else $error("running slot emptied");

endmodule
`default_nettype wire

@@ tb/sv/mlfq_four_level_scheduler_tb.sv @@
// Self-checking testbench for mlfq_four_level_scheduler: directed table, then random phases
// across several quantum settings, each untyped request checked against an in-bench predictor.
// Depends on mlfq_pkg and the design files; needs nothing else.
module mlfq_four_level_scheduler_tb;
   import mlfq_pkg::*;

   localparam int QDEPTH = 16;
   localparam int STALL_LIMIT = 1000;
   localparam int REQS_PER_PHASE = 200;
   localparam int PHASES = 6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LOW  = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HIGH = '1;

   typedef struct packed {
      logic              op;
      logic [7:0]        id;
      logic signed [3:0] prio;
      logic              exec;
   } sched_req_t;

   typedef struct packed {
      logic       busy_res;
      logic [7:0] running_id;
      lvl_type    running_level;
      logic       switched;
      logic       dropped;
   } slot_status_t;

   typedef struct packed {
      sched_req_t   rq;
      logic [4:0]   reps;
      logic         typed;
      slot_status_t want;
   } dir_row_t;

   localparam slot_status_t IDLE_STATUS = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_ADD;
   logic [7:0] req_proc_id = '0;
   logic signed [3:0] req_proc_priority = '0;
   logic req_executed = 1'b0;
   logic rsp_valid;
   logic rsp_busy_res;
   logic [7:0] rsp_running_id;
   logic [LVL_BITS-1:0] rsp_running_level;
   logic rsp_switched;
   logic rsp_dropped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [QUANTUM_BITS-1:0] csr_data = '0;

   quantum_type quanta [LEVELS];
   logic [7:0] fifo_mem [LEVELS][QDEPTH];
   logic [3:0] fifo_head [LEVELS];
   logic [4:0] fifo_fill [LEVELS];
   logic slot_on;
   logic [7:0] slot_pid;
   lvl_type slot_lvl;
   used_type slot_used;

   slot_status_t slot_status_q [$];
   dir_row_t dir_rows [16];
   int mismatch_count = 0;
   int sent_count = 0;
   int stall_cycles = 0;

   mlfq_four_level_scheduler u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_proc_id       (req_proc_id),
      .req_proc_priority (req_proc_priority),
      .req_executed      (req_executed),
      .rsp_valid         (rsp_valid),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_running_id    (rsp_running_id),
      .rsp_running_level (rsp_running_level),
      .rsp_switched      (rsp_switched),
      .rsp_dropped       (rsp_dropped),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit fifo_put(input lvl_type l, input logic [7:0] pid);
      if (fifo_fill[l] >= QDEPTH) return 1'b0;
      fifo_mem[l][4'(fifo_head[l] + fifo_fill[l])] = pid;
      fifo_fill[l] = fifo_fill[l] + 5'd1;
      return 1'b1;
   endfunction

   function automatic bit fifo_take(output logic [7:0] pid, output lvl_type l);
      pid = '0;
      l = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (fifo_fill[i] != 0) begin
            pid = fifo_mem[i][fifo_head[i]];
            l = lvl_type'(i);
            fifo_head[i] = fifo_head[i] + 4'd1;
            fifo_fill[i] = fifo_fill[i] - 5'd1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic slot_status_t advance_scheduler(input sched_req_t rq);
      slot_status_t st;
      lvl_type l;
      lvl_type demoted;
      logic [7:0] pid;
      logic [7:0] evicted;
      st = IDLE_STATUS;
      if (rq.op == OP_ADD) begin
         if (rq.prio[3]) l = '0;
         else if (rq.prio[2]) l = TOP_LEVEL;
         else l = rq.prio[1:0];
         if (!fifo_put(l, rq.id)) st.dropped = 1'b1;
      end else if (!slot_on) begin
         if (fifo_take(pid, l)) begin
            slot_on = 1'b1;
            slot_pid = pid;
            slot_lvl = l;
            slot_used = '0;
            st.switched = 1'b1;
         end
      end else begin
         if (rq.exec && slot_used != USED_MAX) slot_used = slot_used + 1'b1;
         if (slot_used >= quanta[slot_lvl]) begin
            demoted = (slot_lvl == TOP_LEVEL) ? TOP_LEVEL : slot_lvl + 1'b1;
            if (fifo_take(pid, l)) begin
               evicted = slot_pid;
               slot_pid = pid;
               slot_lvl = l;
               st.switched = 1'b1;
               if (!fifo_put(demoted, evicted)) st.dropped = 1'b1;
            end else begin
               slot_lvl = demoted;
            end
            slot_used = '0;
         end
      end
      st.busy_res = slot_on;
      st.running_id = slot_on ? slot_pid : '0;
      st.running_level = slot_on ? slot_lvl : '0;
      return st;
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      slot_status_t want;
      if (!reset && rsp_valid) begin
         if (slot_status_q.size() == 0) begin
            $display("%0t: result with no request pending, actual id %0h", $time,
                     rsp_running_id);
            mismatch_count++;
         end else begin
            want = slot_status_q.pop_front();
            check_field("busy_res", want.busy_res, rsp_busy_res);
            check_field("running_id", want.running_id, rsp_running_id);
            check_field("running_level", want.running_level, rsp_running_level);
            check_field("switched", want.switched, rsp_switched);
            check_field("dropped", want.dropped, rsp_dropped);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(input sched_req_t rq, input logic typed,
                               input slot_status_t want);
      slot_status_t predicted;
      if ((sent_count < 300 || sent_count >= 600) && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= rq.op;
      req_proc_id <= rq.id;
      req_proc_priority <= rq.prio;
      req_executed <= rq.exec;
      do @(posedge clock); while (busy);
      predicted = advance_scheduler(rq);
      slot_status_q.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (slot_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic program_quanta(input quantum_type q0, input quantum_type q1,
                                 input quantum_type q2, input quantum_type q3,
                                 input bit stray);
      logic [CSR_INDEX_BITS-1:0] idx [6];
      quantum_type val [6];
      int n;
      idx = '{CSR_QUANTUM0, CSR_QUANTUM1, CSR_QUANTUM2, CSR_QUANTUM3,
              CSR_UNUSED_LOW, CSR_UNUSED_HIGH};
      val = '{q0, q1, q2, q3, quantum_type'($urandom), quantum_type'($urandom)};
      n = stray ? 6 : 4;
      csr_valid <= 1'b1;
      for (int i = 0; i < n; i++) begin
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         if (idx[i] < LEVELS) quanta[idx[i][LVL_BITS-1:0]] = val[i];
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      sched_req_t rq;
      int add_pct;
      quanta = '{QUANTUM0_RESET, QUANTUM1_RESET, QUANTUM2_RESET, QUANTUM3_RESET};
      for (int i = 0; i < LEVELS; i++) begin
         fifo_head[i] = '0;
         fifo_fill[i] = '0;
      end
      slot_on = 1'b0;
      slot_pid = '0;
      slot_lvl = '0;
      slot_used = '0;

      // op, id, priority, executed | repeats | typed | busy, id, level, switched, dropped
      dir_rows[0]  = '{'{OP_TICK, 8'h00, 4'sd0, 1'b0}, 5'd1, 1'b1, IDLE_STATUS};
      dir_rows[1]  = '{'{OP_ADD, 8'h00, 4'sd0, 1'b0}, 5'd1, 1'b1, IDLE_STATUS};
      dir_rows[2]  = '{'{OP_ADD, 8'hFF, -4'sd8, 1'b0}, 5'd1, 1'b1, IDLE_STATUS};
      dir_rows[3]  = '{'{OP_ADD, 8'h10, 4'sd1, 1'b0}, 5'd16, 1'b1, IDLE_STATUS};
      dir_rows[4]  = '{'{OP_ADD, 8'h77, 4'sd1, 1'b1}, 5'd1, 1'b1,
                       '{1'b0, 8'h00, 2'd0, 1'b0, 1'b1}};
      dir_rows[5]  = '{'{OP_ADD, 8'h88, 4'sd7, 1'b0}, 5'd1, 1'b1, IDLE_STATUS};
      dir_rows[6]  = '{'{OP_ADD, 8'h99, 4'sd3, 1'b0}, 5'd1, 1'b1, IDLE_STATUS};
      dir_rows[7]  = '{'{OP_ADD, 8'h44, 4'sd2, 1'b0}, 5'd1, 1'b1, IDLE_STATUS};
      dir_rows[8]  = '{'{OP_TICK, 8'h00, 4'sd0, 1'b1}, 5'd1, 1'b1,
                       '{1'b1, 8'h00, 2'd0, 1'b1, 1'b0}};
      dir_rows[9]  = '{'{OP_TICK, 8'h00, 4'sd0, 1'b1}, 5'd1, 1'b1,
                       '{1'b1, 8'h00, 2'd0, 1'b0, 1'b0}};
      dir_rows[10] = '{'{OP_TICK, 8'h00, 4'sd0, 1'b1}, 5'd1, 1'b1,
                       '{1'b1, 8'hFF, 2'd0, 1'b1, 1'b1}};
      dir_rows[11] = '{'{OP_TICK, 8'h5A, 4'sd5, 1'b0}, 5'd2, 1'b0, IDLE_STATUS};
      dir_rows[12] = '{'{OP_TICK, 8'hA5, -4'sd3, 1'b1}, 5'd2, 1'b0, IDLE_STATUS};
      dir_rows[13] = '{'{OP_ADD, 8'hC3, 4'sd4, 1'b0}, 5'd1, 1'b0, IDLE_STATUS};
      dir_rows[14] = '{'{OP_ADD, 8'h3C, -4'sd1, 1'b1}, 5'd1, 1'b0, IDLE_STATUS};
      dir_rows[15] = '{'{OP_TICK, 8'h00, 4'sd0, 1'b1}, 5'd3, 1'b0, IDLE_STATUS};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         for (int k = 0; k < dir_rows[r].reps; k++) begin
            rq = dir_rows[r].rq;
            rq.id = rq.id + 8'(k);
            send_request(rq, dir_rows[r].typed, dir_rows[r].want);
         end
      end
      drain_results();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               program_quanta(8'd1, 8'd1, 8'd1, 8'd1, 1'b1);
            end
            1: begin
               program_quanta(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
            end
            2: begin
               program_quanta(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
            end
            3: begin
               program_quanta(quantum_type'($urandom), quantum_type'($urandom),
                              quantum_type'($urandom), quantum_type'($urandom), 1'b1);
            end
            4: begin
               program_quanta(quantum_type'($urandom_range(1, 6)),
                              quantum_type'($urandom_range(1, 6)),
                              quantum_type'($urandom_range(1, 6)),
                              quantum_type'($urandom_range(1, 6)), 1'b0);
            end
            default: begin
               program_quanta(8'd255, quantum_type'($urandom_range(1, 12)), 8'd1, 8'd0, 1'b0);
            end
         endcase
         add_pct = (ph % 3 == 0) ? 70 : ((ph % 3 == 1) ? 45 : 25);
         for (int i = 0; i < REQS_PER_PHASE; i++) begin
            rq.op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
            rq.id = 8'($urandom);
            rq.prio = 4'($urandom);
            rq.exec = ($urandom_range(0, 99) < 80);
            send_request(rq, 1'b0, IDLE_STATUS);
         end
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && slot_status_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/mlfq_pkg.sv
design/mlfq_ram.sv
design/mlfq_four_level_scheduler.sv
tb/sv/mlfq_four_level_scheduler_tb.sv
